>>> src/cubic_spline_path_stepper_defines.svh
// Assertion macros shared by the path stepper RTL.
// Depends on nothing; include by bare file name after the timescale line.
`ifndef CUBIC_SPLINE_PATH_STEPPER_DEFINES_SVH
`define CUBIC_SPLINE_PATH_STEPPER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define CSPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CSPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/cspath_pkg.sv
// Shared types, codes and constants of the cubic spline path stepper.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps

package cspath_pkg;

  localparam int POINT_DEPTH_DEF = 256;
  localparam int POINT_W         = 64;
  localparam int PADDR_W         = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_BASE_X = 2'd0,
    REG_BASE_Y = 2'd1,
    REG_BASE_Z = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_APPLY,
    ST_POLY,
    ST_MAC,
    ST_INC,
    ST_UPD
  } state_e;

  // Segment modes
  localparam logic [2:0] MODE_START0  = 3'd1;
  localparam logic [2:0] MODE_START1  = 3'd2;
  localparam logic [2:0] MODE_UNIFORM = 3'd3;
  localparam logic [2:0] MODE_END0    = 3'd4;
  localparam logic [2:0] MODE_END1    = 3'd5;

  // Polynomial step of one weight
  localparam logic [2:0] PSTEP_CUBIC = 3'd0;
  localparam logic [2:0] PSTEP_QUAD  = 3'd1;
  localparam logic [2:0] PSTEP_HI    = 3'd2;
  localparam logic [2:0] PSTEP_LO    = 3'd3;
  localparam logic [2:0] PSTEP_DIV   = 3'd4;

  // floor(x/3) = (x * RECIP3) >> 25 for x < 2^25
  localparam logic [26:0] RECIP3   = 27'd11184811;
  // floor(x/125) = (x * RECIP125) >> 30 for x < 2^23
  localparam logic [26:0] RECIP125 = 27'd8589935;

  localparam logic [15:0] SPEED_MAX = 16'd1000;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  localparam logic signed [40:0] POS_MAX = 41'sd16777215;
  localparam logic signed [40:0] POS_MIN = -41'sd16777216;

  // One basis weight: variable select (1 = u) and 12x cubic..constant coefficients
  typedef struct packed {
    logic              sel;
    logic signed [7:0] c3;
    logic signed [7:0] c2;
    logic signed [7:0] c1;
    logic signed [7:0] c0;
  } coef_t;

  function automatic coef_t coef_of(input logic [2:0] mode, input logic [1:0] k);
    coef_t c;
    c = '0;
    case (mode)
      MODE_START0: begin
        case (k)
          2'd0:    c = '{1'b1, 8'sd12, 8'sd0, 8'sd0, 8'sd0};
          2'd1:    c = '{1'b0, 8'sd21, -8'sd54, 8'sd36, 8'sd0};
          2'd2:    c = '{1'b0, -8'sd11, 8'sd18, 8'sd0, 8'sd0};
          default: c = '{1'b0, 8'sd2, 8'sd0, 8'sd0, 8'sd0};
        endcase
      end
      MODE_START1: begin
        case (k)
          2'd0:    c = '{1'b1, 8'sd3, 8'sd0, 8'sd0, 8'sd0};
          2'd1:    c = '{1'b0, 8'sd7, -8'sd15, 8'sd3, 8'sd7};
          2'd2:    c = '{1'b0, -8'sd6, 8'sd6, 8'sd6, 8'sd2};
          default: c = '{1'b0, 8'sd2, 8'sd0, 8'sd0, 8'sd0};
        endcase
      end
      MODE_UNIFORM: begin
        case (k)
          2'd0:    c = '{1'b1, 8'sd2, 8'sd0, 8'sd0, 8'sd0};
          2'd1:    c = '{1'b0, 8'sd6, -8'sd12, 8'sd0, 8'sd8};
          2'd2:    c = '{1'b0, -8'sd6, 8'sd6, 8'sd6, 8'sd2};
          default: c = '{1'b0, 8'sd2, 8'sd0, 8'sd0, 8'sd0};
        endcase
      end
      MODE_END0: begin
        case (k)
          2'd0:    c = '{1'b1, 8'sd2, 8'sd0, 8'sd0, 8'sd0};
          2'd1:    c = '{1'b1, -8'sd6, 8'sd6, 8'sd6, 8'sd2};
          2'd2:    c = '{1'b1, 8'sd7, -8'sd15, 8'sd3, 8'sd7};
          default: c = '{1'b0, 8'sd3, 8'sd0, 8'sd0, 8'sd0};
        endcase
      end
      MODE_END1: begin
        case (k)
          2'd0:    c = '{1'b1, 8'sd2, 8'sd0, 8'sd0, 8'sd0};
          2'd1:    c = '{1'b1, -8'sd11, 8'sd18, 8'sd0, 8'sd0};
          2'd2:    c = '{1'b1, 8'sd21, -8'sd54, 8'sd36, 8'sd0};
          default: c = '{1'b0, 8'sd12, 8'sd0, 8'sd0, 8'sd0};
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> src/cspath_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the control points of the path stepper.
`timescale 1ns / 1ps

module cspath_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cubic_spline_path_stepper.sv
// Top level of the cubic spline path stepper: sequencer, shared multiplier, APB registers.
// Depends on cspath_pkg, cspath_ram and cubic_spline_path_stepper_defines.svh.
`timescale 1ns / 1ps
`include "cubic_spline_path_stepper_defines.svh"

// Walks a cubic B-spline through a store of POINT_DEPTH control points (speed, x, y, z).
// Beats on the input channel are load (write one point), start (set the first point,
// clear t, enter the first start mode) and tick (evaluate one position and advance t by
// speed/1000). Only a tick yields an output beat: the Q17.8 position, base offset added
// and saturated to 25 bits, plus a finished flag when the last segment wraps. One shared
// signed 27x27 multiplier does all the arithmetic. A tick runs five multiplier passes
// per basis weight (Horner steps plus a reciprocal divide by 3), three coordinate
// multiply-accumulates per weight, one pass for the t increment and an update state
// that registers the result. Load and start pass through a reduce state, which
// subtracts POINT_DEPTH from the index until it lies below the depth, then an apply state.
// The block stalls its input while it works; a finished result waits in the output
// register and the next beat is taken meanwhile, but the following tick holds in its
// update state until that result is taken. Points sit in a RAM with no reset; reading a
// point that was never loaded gives undefined positions. base_x/y/z live at byte
// addresses 0, 4 and 8 of the APB port.
module cubic_spline_path_stepper #(
  parameter int POINT_DEPTH = cspath_pkg::POINT_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [7:0]                       point_index_i,
  input  logic signed [15:0]               point_speed_i,
  input  logic signed [15:0]               point_x_i,
  input  logic signed [15:0]               point_y_i,
  input  logic signed [15:0]               point_z_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [24:0]               pos_x_o,
  output logic signed [24:0]               pos_y_o,
  output logic signed [24:0]               pos_z_o,
  output logic                             finished_o,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cspath_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int IdxW = $clog2(POINT_DEPTH);
  localparam int RedW = (IdxW > 8) ? IdxW : 8;
  localparam logic [IdxW:0] DepthI = (IdxW + 1)'(POINT_DEPTH);
  localparam logic [RedW:0] DepthR = (RedW + 1)'(POINT_DEPTH);

  // ---------------------------------------------------------------- registers
  cspath_pkg::state_e state_q, state_d;
  cspath_pkg::op_e    op_q, op_d;

  logic [RedW-1:0]          red_q, red_d;
  logic [63:0]              wdata_q, wdata_d;
  logic [IdxW-1:0]          read_index_q, read_index_d;
  logic [15:0]              t_q, t_d;
  logic [2:0]               mode_q, mode_d;
  logic [1:0]               k_q, k_d;
  logic [2:0]               step_q, step_d;
  logic signed [59:0]       poly_q, poly_d;
  logic [18:0]              lo_q, lo_d;
  logic signed [19:0]       w_q, w_d;
  logic signed [39:0]       pacc_q [3];
  logic signed [39:0]       pacc_d [3];
  logic [15:0]              speed0_q, speed0_d;
  logic [15:0]              speed3_q, speed3_d;
  logic [16:0]              inc_q, inc_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [24:0]       pos_q [3];
  logic signed [24:0]       pos_d [3];
  logic                     fin_q, fin_d;
  logic signed [15:0]       base_q [3];

  // ---------------------------------------------------------------- wiring
  logic                     in_fire;
  logic                     out_hold;
  logic                     mem_we;
  logic                     mem_re;
  logic [IdxW-1:0]          mem_raddr;
  logic [63:0]              mem_rdata;
  logic signed [26:0]       mul_a;
  logic signed [26:0]       mul_b;
  logic signed [53:0]       prod;
  cspath_pkg::coef_t        coef;
  logic [16:0]              tvar;
  logic [IdxW:0]            pt_sum;
  logic [IdxW-1:0]          pt_addr;
  logic [IdxW:0]            nx_sum;
  logic [IdxW-1:0]          nx_index;
  logic signed [59:0]       qv;
  logic [23:0]              rdiv;
  logic [9:0]               speed_c;
  logic [17:0]              t_sum;
  logic signed [15:0]       coord;
  logic                     red_big;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_q && out_stall_i;
  assign red_big  = {1'b0, red_q} >= DepthR;

  // Shared multiplier
  assign prod = mul_a * mul_b;

  // Weight coefficients and the curve variable they use
  assign coef = cspath_pkg::coef_of(mode_q, k_q);
  assign tvar = coef.sel ? (cspath_pkg::ONE_Q16 - {1'b0, t_q}) : {1'b0, t_q};

  // Point k of the current window, modulo the store depth
  assign pt_sum  = {1'b0, read_index_q} + (IdxW + 1)'(k_q);
  assign pt_addr = (pt_sum >= DepthI) ? IdxW'(pt_sum - DepthI) : pt_sum[IdxW-1:0];
  assign nx_sum   = {1'b0, read_index_q} + (IdxW + 1)'(1);
  assign nx_index = (nx_sum >= DepthI) ? IdxW'(nx_sum - DepthI) : nx_sum[IdxW-1:0];

  // Round-half-up of P / 2^32 / 12: add 6 after the shift, drop two bits, divide by 3
  assign qv   = (poly_q >>> 32) + 60'sd6;
  assign rdiv = qv[25:2];

  // Clamp the speed word to 0..1000
  always_comb begin
    if (speed0_q[15]) begin
      speed_c = '0;
    end else if (speed0_q > cspath_pkg::SPEED_MAX) begin
      speed_c = cspath_pkg::SPEED_MAX[9:0];
    end else begin
      speed_c = speed0_q[9:0];
    end
  end

  assign t_sum = {2'b00, t_q} + {1'b0, inc_q};

  always_comb begin
    case (step_q)
      3'd0:    coord = $signed(mem_rdata[31:16]);
      3'd1:    coord = $signed(mem_rdata[47:32]);
      default: coord = $signed(mem_rdata[63:48]);
    endcase
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      cspath_pkg::ST_POLY: begin
        mul_b = 27'(tvar);
        case (step_q)
          cspath_pkg::PSTEP_CUBIC: mul_a = 27'(coef.c3);
          cspath_pkg::PSTEP_QUAD:  mul_a = 27'(poly_q);
          cspath_pkg::PSTEP_HI:    mul_a = 27'(poly_q >>> 19);
          cspath_pkg::PSTEP_LO:    mul_a = 27'({1'b0, lo_q});
          default: begin
            mul_a = 27'(rdiv);
            mul_b = cspath_pkg::RECIP3;
          end
        endcase
      end
      cspath_pkg::ST_MAC: begin
        mul_a = 27'(w_q);
        mul_b = 27'(coord);
      end
      cspath_pkg::ST_INC: begin
        // (speed * 65536 + 500) / 8 = speed * 8192 + 62, then divide by 125
        mul_a = 27'({speed_c, 13'd62});
        mul_b = cspath_pkg::RECIP125;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round an accumulator to Q.8, add the base and saturate
  function automatic logic signed [24:0] pos_of(input logic signed [39:0] acc,
                                                input logic signed [15:0] base);
    logic signed [39:0] rnd;
    logic signed [40:0] full;
    rnd  = (acc + 40'sd128) >>> 8;
    full = 41'(rnd) + (41'(base) <<< 8);
    if (full > cspath_pkg::POS_MAX) begin
      return cspath_pkg::POS_MAX[24:0];
    end else if (full < cspath_pkg::POS_MIN) begin
      return cspath_pkg::POS_MIN[24:0];
    end
    return full[24:0];
  endfunction

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cspath_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            cspath_pkg::OP_LOAD,
            cspath_pkg::OP_START: state_d = cspath_pkg::ST_REDUCE;
            cspath_pkg::OP_TICK:  state_d = cspath_pkg::ST_POLY;
            default:              state_d = cspath_pkg::ST_IDLE;
          endcase
        end
      end
      cspath_pkg::ST_REDUCE: begin
        if (!red_big) state_d = cspath_pkg::ST_APPLY;
      end
      cspath_pkg::ST_APPLY: state_d = cspath_pkg::ST_IDLE;
      cspath_pkg::ST_POLY: begin
        if (step_q == cspath_pkg::PSTEP_DIV) state_d = cspath_pkg::ST_MAC;
      end
      cspath_pkg::ST_MAC: begin
        if (step_q == 3'd2) begin
          state_d = (k_q == 2'd3) ? cspath_pkg::ST_INC : cspath_pkg::ST_POLY;
        end
      end
      cspath_pkg::ST_INC: state_d = cspath_pkg::ST_UPD;
      cspath_pkg::ST_UPD: begin
        if (!out_hold) state_d = cspath_pkg::ST_IDLE;
      end
      default: state_d = cspath_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    op_d         = op_q;
    red_d        = red_q;
    wdata_d      = wdata_q;
    read_index_d = read_index_q;
    t_d          = t_q;
    mode_d       = mode_q;
    k_d          = k_q;
    step_d       = step_q;
    poly_d       = poly_q;
    lo_d         = lo_q;
    w_d          = w_q;
    pacc_d       = pacc_q;
    speed0_d     = speed0_q;
    speed3_d     = speed3_q;
    inc_d        = inc_q;
    pos_d        = pos_q;
    fin_d        = fin_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = pt_addr;
    // Drop the waiting result once taken
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      cspath_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d    = cspath_pkg::op_e'(op_i);
          red_d   = RedW'(point_index_i);
          wdata_d = {point_z_i, point_y_i, point_x_i, point_speed_i};
          k_d     = '0;
          step_d  = '0;
          for (int a = 0; a < 3; a++) pacc_d[a] = '0;
        end
      end
      cspath_pkg::ST_REDUCE: begin
        if (red_big) red_d = RedW'({1'b0, red_q} - DepthR);
      end
      cspath_pkg::ST_APPLY: begin
        if (op_q == cspath_pkg::OP_LOAD) begin
          mem_we = 1'b1;
        end else begin
          read_index_d = red_q[IdxW-1:0];
          t_d          = '0;
          mode_d       = cspath_pkg::MODE_START0;
        end
      end
      cspath_pkg::ST_POLY: begin
        step_d = step_q + 3'd1;
        case (step_q)
          cspath_pkg::PSTEP_CUBIC: begin
            mem_re = 1'b1;
            poly_d = 60'(prod) + (60'(coef.c2) <<< 16);
          end
          cspath_pkg::PSTEP_QUAD: begin
            poly_d = 60'(prod) + (60'(coef.c1) <<< 32);
          end
          cspath_pkg::PSTEP_HI: begin
            lo_d   = poly_q[18:0];
            poly_d = (60'(prod) <<< 19) + (60'(coef.c0) <<< 48);
          end
          cspath_pkg::PSTEP_LO: begin
            poly_d = poly_q + 60'(prod);
          end
          default: begin
            w_d    = prod[44:25];
            step_d = '0;
          end
        endcase
      end
      cspath_pkg::ST_MAC: begin
        for (int a = 0; a < 3; a++) begin
          if (step_q == 3'(a)) pacc_d[a] = pacc_q[a] + 40'(prod);
        end
        if (step_q == 3'd0 && k_q == 2'd0) speed0_d = mem_rdata[15:0];
        if (step_q == 3'd0 && k_q == 2'd3) speed3_d = mem_rdata[15:0];
        if (step_q == 3'd2) begin
          step_d = '0;
          k_d    = k_q + 2'd1;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      cspath_pkg::ST_INC: begin
        inc_d = prod[46:30];
      end
      cspath_pkg::ST_UPD: begin
        if (!out_hold) begin
          out_valid_d = 1'b1;
          for (int a = 0; a < 3; a++) pos_d[a] = pos_of(pacc_q[a], base_q[a]);
          fin_d = 1'b0;
          if (t_sum >= {1'b0, cspath_pkg::ONE_Q16}) begin
            // Wrap: advance the window and step the segment mode, or flag finished in the last mode
            t_d          = t_sum[15:0];
            read_index_d = nx_index;
            case (mode_q)
              cspath_pkg::MODE_END1: fin_d = 1'b1;
              cspath_pkg::MODE_UNIFORM: begin
                if (speed3_q == 16'd0) mode_d = cspath_pkg::MODE_END0;
              end
              default: mode_d = mode_q + 3'd1;
            endcase
          end else begin
            t_d = t_sum[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cspath_pkg::ST_IDLE;
      op_q         <= cspath_pkg::OP_LOAD;
      read_index_q <= '0;
      t_q          <= '0;
      mode_q       <= cspath_pkg::MODE_START0;
      k_q          <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      read_index_q <= read_index_d;
      t_q          <= t_d;
      mode_q       <= mode_d;
      k_q          <= k_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q    <= red_d;
    wdata_q  <= wdata_d;
    poly_q   <= poly_d;
    lo_q     <= lo_d;
    w_q      <= w_d;
    pacc_q   <= pacc_d;
    speed0_q <= speed0_d;
    speed3_q <= speed3_d;
    inc_q    <= inc_d;
    pos_q    <= pos_d;
    fin_q    <= fin_d;
  end

  // ---------------------------------------------------------------- point store
  cspath_ram #(
    .Width (cspath_pkg::POINT_W),
    .Depth (POINT_DEPTH)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (red_q[IdxW-1:0]),
    .wdata_i (wdata_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------- APB registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) base_q[a] <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        cspath_pkg::REG_BASE_X: base_q[0] <= pwdata[15:0];
        cspath_pkg::REG_BASE_Y: base_q[1] <= pwdata[15:0];
        cspath_pkg::REG_BASE_Z: base_q[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cspath_pkg::REG_BASE_X: prdata = 32'(base_q[0]);
      cspath_pkg::REG_BASE_Y: prdata = 32'(base_q[1]);
      cspath_pkg::REG_BASE_Z: prdata = 32'(base_q[2]);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- ports
  assign in_stall_o  = (state_q != cspath_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign finished_o  = fin_q;

  // ---------------------------------------------------------------- assertions
  `CSPS_ASSERT(a_index_range, clk_i, rst_ni, {1'b0, read_index_q} < DepthI, "read index beyond store depth")
  `CSPS_ASSERT(a_mode_range, clk_i, rst_ni, (mode_q >= cspath_pkg::MODE_START0) && (mode_q <= cspath_pkg::MODE_END1), "segment mode left its range")
  `CSPS_ASSERT_IMPL(a_out_source, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == cspath_pkg::ST_UPD), "result raised outside the update cycle")

endmodule

>>> test/tb_top.sv
// Self-checking bench for the cubic spline path stepper: random paths, ticks and noise.
// Depends on cspath_pkg and the cubic_spline_path_stepper RTL.
`timescale 1ns / 1ps

module tb_top;

  // One input beat as it sits in the pending queue
  typedef struct {
    logic [1:0]         op;
    logic [7:0]         idx;
    logic signed [15:0] spd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } beat_t;

  // One evaluated position as the block should emit it
  typedef struct {
    logic signed [24:0] px;
    logic signed [24:0] py;
    logic signed [24:0] pz;
    logic               fin;
  } pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = '0;
  logic [7:0]         in_idx = '0;
  logic signed [15:0] in_spd = '0;
  logic signed [15:0] in_x = '0;
  logic signed [15:0] in_y = '0;
  logic signed [15:0] in_z = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [24:0] pos_x, pos_y, pos_z;
  logic               finished;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [cspath_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  cubic_spline_path_stepper dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .op_i(in_op),
    .point_index_i(in_idx), .point_speed_i(in_spd),
    .point_x_i(in_x), .point_y_i(in_y), .point_z_i(in_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .pos_z_o(pos_z), .finished_o(finished),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  beat_t pending_beats[$];
  pos_t  expected_pos[$];
  int    errors = 0;
  int    beats_sent = 0;
  int    positions_checked = 0;
  int    finishes_seen = 0;
  int    cycle = 0;
  int    n_queued = 0;
  int    n_settings = 0;

  // Idle stretch: random gaps, except that every fourth block of cycles runs with no gaps at all
  function automatic bit take_gap();
    return ((cycle / 8000) % 4 != 3) && ($urandom_range(99) < 10);
  endfunction

  // Driver: hold the beat while stalled, advance on accept
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) beats_sent <= beats_sent + 1;
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && !take_gap()) begin
          in_op    <= pending_beats[0].op;
          in_idx   <= pending_beats[0].idx;
          in_spd   <= pending_beats[0].spd;
          in_x     <= pending_beats[0].x;
          in_y     <= pending_beats[0].y;
          in_z     <= pending_beats[0].z;
          in_valid <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Monitor: compare each accepted position beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pos.size() == 0) begin
          report_mismatch($sformatf("unexpected beat x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z));
        end else begin
          if (pos_x !== expected_pos[0].px)
            report_mismatch($sformatf("pos_x %0d, want %0d", pos_x, expected_pos[0].px));
          if (pos_y !== expected_pos[0].py)
            report_mismatch($sformatf("pos_y %0d, want %0d", pos_y, expected_pos[0].py));
          if (pos_z !== expected_pos[0].pz)
            report_mismatch($sformatf("pos_z %0d, want %0d", pos_z, expected_pos[0].pz));
          if (finished !== expected_pos[0].fin)
            report_mismatch($sformatf("finished %0b, want %0b", finished, expected_pos[0].fin));
          if (expected_pos[0].fin) finishes_seen <= finishes_seen + 1;
          positions_checked <= positions_checked + 1;
          void'(expected_pos.pop_front());
        end
      end
      out_stall <= take_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Path predictor: point store, walk state and base offsets
  // ---------------------------------------------------------------------------
  logic signed [15:0] pt_spd[256], pt_x[256], pt_y[256], pt_z[256];
  bit                 pt_loaded[256];
  logic [7:0]         walk_idx = '0;
  logic [16:0]        walk_t = '0;
  logic [2:0]         walk_mode = cspath_pkg::MODE_START0;
  logic signed [15:0] base[3] = '{0, 0, 0};
  bit                 last_fin;

  // Basis weights per mode: variable (1 = u), then 12x cubic, quadratic, linear, constant
  int basis_coef[8][4][5] = '{
    '{'{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
    '{'{1,12,0,0,0}, '{0,21,-54,36,0}, '{0,-11,18,0,0}, '{0,2,0,0,0}},
    '{'{1,3,0,0,0}, '{0,7,-15,3,7}, '{0,-6,6,6,2}, '{0,2,0,0,0}},
    '{'{1,2,0,0,0}, '{0,6,-12,0,8}, '{0,-6,6,6,2}, '{0,2,0,0,0}},
    '{'{1,2,0,0,0}, '{1,-6,6,6,2}, '{1,7,-15,3,7}, '{0,3,0,0,0}},
    '{'{1,2,0,0,0}, '{1,-11,18,0,0}, '{1,21,-54,36,0}, '{0,12,0,0,0}},
    '{'{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
    '{'{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}}
  };

  // Divide rounding to nearest, halves upward
  function automatic longint round_half_up(input longint p, input longint d);
    longint n;
    n = p + d / 2;
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic signed [24:0] saturate_pos(input longint v);
    if (v > 64'sd16777215) v = 64'sd16777215;
    if (v < -64'sd16777216) v = -64'sd16777216;
    return v[24:0];
  endfunction

  // Evaluate the current segment, then advance t, the index and the mode
  task automatic predict_tick();
    longint tv[2];
    longint acc[3];
    longint v, p, w, spd, inc, sum;
    logic [7:0] k;
    pos_t r;
    tv[0] = walk_t;
    tv[1] = 65536 - longint'(walk_t);
    acc = '{0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      v = tv[basis_coef[walk_mode][i][0]];
      // Keep every term signed so negative coefficients extend correctly
      p = basis_coef[walk_mode][i][1] * v * v * v
        + basis_coef[walk_mode][i][2] * v * v * 64'sd65536
        + basis_coef[walk_mode][i][3] * v * 64'sd4294967296
        + basis_coef[walk_mode][i][4] * 64'sd281474976710656;
      w = round_half_up(p, 64'sd51539607552);
      k = walk_idx + i[7:0];
      acc[0] += w * pt_x[k];
      acc[1] += w * pt_y[k];
      acc[2] += w * pt_z[k];
    end
    r.px = saturate_pos(longint'(base[0]) * 256 + round_half_up(acc[0], 256));
    r.py = saturate_pos(longint'(base[1]) * 256 + round_half_up(acc[1], 256));
    r.pz = saturate_pos(longint'(base[2]) * 256 + round_half_up(acc[2], 256));
    r.fin = 1'b0;
    spd = pt_spd[walk_idx];
    if (spd < 0) spd = 0;
    if (spd > 1000) spd = 1000;
    inc = (spd * 65536 + 500) / 1000;
    sum = walk_t + inc;
    if (sum >= 65536) begin
      walk_t = sum - 65536;
      walk_idx = walk_idx + 8'd1;
      if (walk_mode == cspath_pkg::MODE_END1) r.fin = 1'b1;
      else if (walk_mode == cspath_pkg::MODE_UNIFORM) begin
        if (pt_spd[8'(walk_idx + 8'd2)] == 0) walk_mode = cspath_pkg::MODE_END0;
      end else walk_mode = walk_mode + 3'd1;
    end else begin
      walk_t = sum;
    end
    last_fin = r.fin;
    expected_pos.push_back(r);
  endtask

  // Queue one beat and apply it to the predictor
  task automatic send_beat(input logic [1:0] op, input logic [7:0] idx,
                           input logic signed [15:0] spd, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z);
    beat_t b;
    b = '{op, idx, spd, x, y, z};
    pending_beats.push_back(b);
    n_queued++;
    last_fin = 1'b0;
    case (op)
      cspath_pkg::OP_LOAD: begin
        pt_spd[idx] = spd; pt_x[idx] = x; pt_y[idx] = y; pt_z[idx] = z;
        pt_loaded[idx] = 1'b1;
      end
      cspath_pkg::OP_START: begin
        walk_idx = idx; walk_t = '0; walk_mode = cspath_pkg::MODE_START0;
      end
      cspath_pkg::OP_TICK: predict_tick();
      default: ;
    endcase
  endtask

  task automatic load_random(input logic [7:0] idx, input logic signed [15:0] spd);
    send_beat(cspath_pkg::OP_LOAD, idx, spd, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Fill never-loaded slots of the four-point window first, then tick with junk payload
  task automatic tick();
    logic [7:0] k;
    for (int i = 0; i < 4; i++) begin
      k = walk_idx + i[7:0];
      if (!pt_loaded[k]) load_random(k, 16'($urandom_range(1, 1000)));
    end
    send_beat(cspath_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  // Well-formed path: run of moving points, then a stop word
  task automatic run_path();
    logic [7:0] p;
    int len, n;
    p = 8'($urandom);
    len = $urandom_range(5, 10);
    for (int j = 0; j < len; j++)
      load_random(p + 8'(j), 16'($urandom_range(0, 3) == 0 ? $urandom_range(1, 1000)
                                                          : $urandom_range(300, 1000)));
    load_random(p + 8'(len), 16'd0);
    load_random(p + 8'(len + 1), 16'($urandom));
    load_random(p + 8'(len + 2), 16'($urandom));
    send_beat(cspath_pkg::OP_START, p, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    n = 0;
    while (!last_fin && n < 80) begin
      tick();
      n++;
    end
    repeat ($urandom_range(0, 2)) tick();
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = n_queued + count;
    while (n_queued < stop_at) begin
      if ($urandom_range(99) < 70) run_path();
      else begin
        case ($urandom_range(3))
          0: load_random(8'($urandom), 16'($urandom));
          1: send_beat(cspath_pkg::OP_START, 8'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
          2: tick();
          default: send_beat(2'd3, 8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
        endcase
      end
    end
  endtask

  // Drain everything in flight, then let the last tick settle before a register write
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_pos.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cspath_pkg::reg_e r, input logic signed [15:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= cspath_pkg::PADDR_W'({r, 2'b00});
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    base[r] = val;
  endtask

  task automatic set_bases(input logic signed [15:0] bx, input logic signed [15:0] by,
                           input logic signed [15:0] bz);
    drain();
    write_reg(cspath_pkg::REG_BASE_X, bx);
    write_reg(cspath_pkg::REG_BASE_Y, by);
    write_reg(cspath_pkg::REG_BASE_Z, bz);
    n_settings++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, op 3, index wrap, speed clamp and saturation
    send_beat(2'd3, 8'hFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_beat(cspath_pkg::OP_LOAD, 8'd252, -16'sd32768, 16'sh7FFF, -16'sd32768, 16'sh7FFF);
    send_beat(cspath_pkg::OP_LOAD, 8'd253, 16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768);
    send_beat(cspath_pkg::OP_LOAD, 8'd254, 16'sd1000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_beat(cspath_pkg::OP_LOAD, 8'd255, 16'sd1001, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_beat(cspath_pkg::OP_LOAD, 8'd0, 16'sd1, -16'sd32768, -16'sd32768, -16'sd32768);
    send_beat(cspath_pkg::OP_LOAD, 8'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_beat(cspath_pkg::OP_LOAD, 8'd2, 16'sd500, 16'sd1, -16'sd1, 16'sd0);
    send_beat(cspath_pkg::OP_START, 8'd252, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    tick();                   // negative speed: t stays put
    send_beat(cspath_pkg::OP_START, 8'd253, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    repeat (6) tick();        // saturated speeds wrap the window across index 255 to the slow point 0
    set_bases(16'sh7FFF, -16'sd32768, 16'sh7FFF);
    send_beat(cspath_pkg::OP_START, 8'd254, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    repeat (4) tick();        // positions saturate against the base offsets
    run_random(500);

    set_bases(-16'sd32768, 16'sh7FFF, -16'sd32768);
    run_random(500);
    set_bases(16'($urandom), 16'($urandom), 16'($urandom));
    run_random(500);
    set_bases(16'sd0, 16'sd0, 16'sd0);
    run_random(500);

    drain();
    $display("Checked %0d positions (%0d finished) from %0d beats over %0d base settings.",
             positions_checked, finishes_seen, beats_sent, n_settings + 1);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule
